// File: hw/rtl/snpm_pkg.sv
// Package for the sweep nearest position match unit.
// Types, request codes and constants for the match unit; no dependencies.
package snpm_pkg;

  localparam int unsigned MaxEntriesDefault = 4096;
  localparam logic [19:0] RadiusReset = 20'd64;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               coords_valid;
    logic               already_found;
  } req_t;

  typedef struct packed {
    logic        matched;
    logic [11:0] entry_index;
    logic [39:0] dist_sq;
    logic [15:0] entry_hits;
    logic [31:0] total_matches;
    logic        load_error;
    logic        query_order_error;
  } rsp_t;

endpackage

// File: hw/rtl/snpm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module snpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/sweep_nearest_position_match_unit.sv
// Sweep nearest position match unit: catalog RAMs plus the sweep/scan sequencer.
// Depends on snpm_pkg and snpm_ram.
//
// Catalog entries are loaded in ascending X, then queries in ascending X. A
// load or clear completes as it is accepted. A query sweeps past entries,
// then scans the entries in the X window. Every entry visit is one read of
// the entry RAM (registered read data), then a registered difference; a
// scan visit adds a registered 34x34 square stage before the compare. A hit
// adds a read-modify-write of the hit count RAM. Results wait in an output
// register; a new request is taken once the previous query's result has left.
module sweep_nearest_position_match_unit
  import snpm_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [19:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  snpm_pkg::req_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output snpm_pkg::rsp_t    out_data_o
);

  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MaxCount = CW'(MaxEntries);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWRD  = 4'd1;  // sweep: read issued
  localparam logic [3:0] S_SWDF  = 4'd2;  // sweep: data, diff registered
  localparam logic [3:0] S_SWCK  = 4'd3;  // sweep: decide
  localparam logic [3:0] S_SCRD  = 4'd4;  // scan: read issued
  localparam logic [3:0] S_SCDF  = 4'd5;  // scan: diffs
  localparam logic [3:0] S_SCSQ  = 4'd6;  // scan: squares
  localparam logic [3:0] S_SCCK  = 4'd7;  // scan: compare
  localparam logic [3:0] S_HTRD  = 4'd8;  // hit count read
  localparam logic [3:0] S_HTWR  = 4'd9;  // hit count write, result
  localparam logic [3:0] S_DONE  = 4'd10; // emit no-hit result

  logic [3:0] state_q, state_d;
  logic [19:0] radius_q;
  logic [CW-1:0] count_q, sweep_q, ptr_q;
  logic signed [31:0] last_load_q, last_query_q;
  logic [31:0] total_q;
  logic load_err_q;
  req_t req_q;
  logic hit_q;
  logic [AW-1:0] best_q;
  logic [39:0] best_d_q, lim_q;
  logic signed [33:0] dx_q, dy_q;
  logic [65:0] dxx_q, dyy_q;
  logic ent_ok_q;
  logic out_valid_q;
  rsp_t out_q;

  // Entry RAM word: valid, y, x
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [64:0] ram_wdata, ram_rdata;
  logic hc_we;
  logic [AW-1:0] hc_addr;
  logic [15:0] hc_wdata, hc_rdata;

  snpm_ram #(.Width(65), .Depth(MaxEntries)) u_ent_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  snpm_ram #(.Width(16), .Depth(MaxEntries)) u_hit_ram (
    .clk_i, .we_i(hc_we), .waddr_i(hc_addr), .wdata_i(hc_wdata),
    .raddr_i(hc_addr), .rdata_o(hc_rdata)
  );

  logic accept;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Window terms: 50*dx versus +-51*R, all 41 bits signed
  logic signed [40:0] win, dx50;
  logic signed [33:0] dx_now;
  logic signed [31:0] ent_x, ent_y;
  logic ent_v;
  assign ent_x  = ram_rdata[31:0];
  assign ent_y  = ram_rdata[63:32];
  assign ent_v  = ram_rdata[64];
  assign win    = 41'sd51 * $signed({21'd0, radius_q});
  assign dx_now = 34'(req_q.pos_x) - 34'(ent_x);
  assign dx50   = 41'(dx_q) * 41'sd50;

  logic signed [33:0] rad_s;
  assign rad_s = $signed({14'd0, radius_q});
  logic [40:0] dsum;
  assign dsum = 41'(dxx_q) + 41'(dyy_q);

  logic [CW-1:0] ptr_inc;
  assign ptr_inc = ptr_q + CW'(1);
  assign ram_raddr = ptr_q[AW-1:0];
  assign ram_we    = accept && (in_data_i.req_type == REQ_LOAD) && (count_q < MaxCount) &&
                     !(in_data_i.coords_valid && (in_data_i.pos_x < last_load_q));
  assign ram_waddr = count_q[AW-1:0];
  assign ram_wdata = {in_data_i.coords_valid, in_data_i.pos_y, in_data_i.pos_x};

  logic [15:0] hc_next;
  assign hc_next  = (hc_rdata == 16'hFFFF) ? hc_rdata : hc_rdata + 16'd1;
  assign hc_addr  = ram_we ? ram_waddr : best_q;
  assign hc_we    = ram_we || (state_q == S_HTWR);
  assign hc_wdata = ram_we ? 16'd0 : hc_next;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && in_data_i.req_type == REQ_QUERY && in_data_i.coords_valid &&
                  in_data_i.pos_x >= last_query_q) begin
        state_d = S_SWRD;
      end
      S_SWRD: state_d = (ptr_q < count_q) ? S_SWDF : S_DONE;
      S_SWDF: state_d = S_SWCK;
      S_SWCK: begin
        if (!ent_ok_q || (dx50 > -win && dx50 >= win)) state_d = S_SWRD;
        else if (!req_q.already_found && dx50 > -win) state_d = S_SCRD;
        else state_d = S_DONE;
      end
      S_SCRD: state_d = (ptr_q < count_q) ? S_SCDF : (hit_q ? S_HTRD : S_DONE);
      S_SCDF: state_d = S_SCSQ;
      S_SCSQ: state_d = S_SCCK;
      S_SCCK: state_d = (dx50 <= -win) ? (hit_q ? S_HTRD : S_DONE) : S_SCRD;
      S_HTRD: state_d = S_HTWR;
      S_HTWR: state_d = S_IDLE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      radius_q     <= RadiusReset;
      count_q      <= '0;
      sweep_q      <= '0;
      ptr_q        <= '0;
      last_load_q  <= 32'sh8000_0000;
      last_query_q <= 32'sh8000_0000;
      total_q      <= '0;
      load_err_q   <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) radius_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (accept) begin
        unique case (req_e'(in_data_i.req_type))
          REQ_CLEAR: begin
            count_q      <= '0;
            sweep_q      <= '0;
            last_load_q  <= 32'sh8000_0000;
            last_query_q <= 32'sh8000_0000;
            total_q      <= '0;
            load_err_q   <= 1'b0;
          end
          REQ_LOAD: begin
            if (ram_we) begin
              count_q <= count_q + CW'(1);
              if (in_data_i.coords_valid) last_load_q <= in_data_i.pos_x;
            end else begin
              load_err_q <= 1'b1;
            end
          end
          REQ_QUERY: begin
            hit_q <= 1'b0;
            ptr_q <= sweep_q;
            if (state_d == S_IDLE) out_valid_q <= 1'b1;
            else last_query_q <= in_data_i.pos_x;
          end
          default: ;
        endcase
      end
      unique case (state_q)
        S_SWRD: if (ptr_q >= count_q) sweep_q <= ptr_q;
        S_SWCK: begin
          if (state_d == S_SWRD) ptr_q <= ptr_inc;
          else sweep_q <= ptr_q;
        end
        S_SCCK: begin
          if (state_d == S_SCRD) ptr_q <= ptr_inc;
          if (dx50 > -win && ent_ok_q && dsum < 41'(lim_q)) hit_q <= 1'b1;
        end
        S_HTWR: begin
          out_valid_q <= 1'b1;
          if (total_q != 32'hFFFF_FFFF) total_q <= total_q + 32'd1;
        end
        S_DONE: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_data_i;
      lim_q    <= 40'(radius_q) * 40'(radius_q);
      best_q   <= '0;
      best_d_q <= '0;
    end
    if (state_q == S_SWDF || state_q == S_SCDF) begin
      dx_q     <= dx_now;
      dy_q     <= 34'(req_q.pos_y) - 34'(ent_y);
      ent_ok_q <= ent_v;
    end
    if (state_q == S_SCSQ) begin
      dxx_q    <= 66'(dx_q * dx_q);
      dyy_q    <= 66'(dy_q * dy_q);
      ent_ok_q <= ent_ok_q && dx_q < rad_s && -dx_q < rad_s && dy_q < rad_s &&
                  -dy_q < rad_s;
    end
    if (state_q == S_SCCK && dx50 > -win && ent_ok_q && dsum < 41'(lim_q)) begin
      lim_q    <= dsum[39:0];
      best_d_q <= dsum[39:0];
      best_q   <= ptr_q[AW-1:0];
    end
    // Result beat
    if (state_q == S_HTWR) begin
      out_q.matched           <= 1'b1;
      out_q.entry_index       <= 12'(best_q);
      out_q.dist_sq           <= best_d_q;
      out_q.entry_hits        <= hc_next;
      out_q.total_matches     <= (total_q != 32'hFFFF_FFFF) ? total_q + 32'd1 : total_q;
      out_q.load_error        <= load_err_q;
      out_q.query_order_error <= 1'b0;
    end else if (state_q == S_DONE ||
                 (accept && in_data_i.req_type == REQ_QUERY && state_d == S_IDLE)) begin
      out_q.matched           <= 1'b0;
      out_q.entry_index       <= '0;
      out_q.dist_sq           <= '0;
      out_q.entry_hits        <= '0;
      out_q.total_matches     <= total_q;
      out_q.load_error        <= load_err_q;
      out_q.query_order_error <= (state_q == S_IDLE) && in_data_i.coords_valid;
    end
  end

endmodule
